// ----- src/indexed_list_insert_delete_unit_macros.svh -----
// Assertion macros shared by the checker of the indexed list unit.
// Depends on nothing; each macro expects i_clk and i_rst_n in scope.
`ifndef INDEXED_LIST_INSERT_DELETE_UNIT_MACROS_SVH
`define INDEXED_LIST_INSERT_DELETE_UNIT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ILID_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define ILID_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/ilid_pkg.sv -----
// Shared types, widths and codes of the indexed list unit.
// Depends on nothing; used by every module of the block.
`default_nettype none
package ilid_pkg;

    localparam int CAPACITY   = 1024;
    localparam int VALUE_BITS = 16;

    // Field widths of the stream items.
    localparam int OP_W     = 3;
    localparam int INDEX_W  = 11;
    localparam int INVAL_W  = 16;
    localparam int READ_W   = 17;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 11;

    localparam int IN_DATA_W  = ((OP_W + INDEX_W + INVAL_W + 7) / 8) * 8;
    localparam int OUT_DATA_W = ((READ_W + STATUS_W + COUNT_W + 7) / 8) * 8;

    // Internal widths.
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = (INDEX_W > CNT_W) ? INDEX_W : CNT_W;

    // Read-out reduction: groups of GROUP cells, then one level over the groups.
    localparam int GROUP  = 32;
    localparam int NGROUP = (CAPACITY + GROUP - 1) / GROUP;

    // Operation codes.
    localparam logic [OP_W-1:0] OP_READ     = 3'd0;
    localparam logic [OP_W-1:0] OP_INS_HEAD = 3'd1;
    localparam logic [OP_W-1:0] OP_INS_TAIL = 3'd2;
    localparam logic [OP_W-1:0] OP_INS_AT   = 3'd3;
    localparam logic [OP_W-1:0] OP_DEL_AT   = 3'd4;

    // Status codes.
    localparam logic [STATUS_W-1:0] ST_DONE      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_INDEX = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;

    typedef enum logic [1:0] {
        CELL_HOLD = 2'd0,
        CELL_INS  = 2'd1,
        CELL_DEL  = 2'd2
    } t_cell_kind;

    // Command broadcast to every cell of the chain.
    typedef struct packed {
        t_cell_kind            kind;
        logic [CMP_W-1:0]      pos;
        logic [VALUE_BITS-1:0] value;
    } t_cell_cmd;

endpackage
`default_nettype wire

// ----- src/ilid_cell.sv -----
// One storage cell of the list chain: holds one entry and shifts with its neighbors.
// Depends on ilid_pkg.
`default_nettype none
module ilid_cell (
    input  wire logic                               i_clk,
    input  wire logic [ilid_pkg::CMP_W-1:0]         i_idx,
    input  wire ilid_pkg::t_cell_cmd                i_cmd,
    input  wire logic [ilid_pkg::VALUE_BITS-1:0]    i_left,
    input  wire logic [ilid_pkg::VALUE_BITS-1:0]    i_right,
    output logic      [ilid_pkg::VALUE_BITS-1:0]    o_value,
    output logic      [ilid_pkg::VALUE_BITS-1:0]    o_rd
);

    logic [ilid_pkg::VALUE_BITS-1:0] r_value;
    logic [ilid_pkg::VALUE_BITS-1:0] n_value;
    logic                            w_hit;
    logic                            w_above;

    assign w_hit   = (i_idx == i_cmd.pos);
    assign w_above = (i_idx > i_cmd.pos);

    always_comb begin
        n_value = r_value;
        case (i_cmd.kind)
            ilid_pkg::CELL_INS: begin
                // open the gap: take from the left, load at the insert point
                if (w_above) begin
                    n_value = i_left;
                end else if (w_hit) begin
                    n_value = i_cmd.value;
                end
            end
            ilid_pkg::CELL_DEL: begin
                // close the gap: take from the right at and above the point
                if (w_above || w_hit) begin
                    n_value = i_right;
                end
            end
            default: begin
                n_value = r_value;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_value = r_value;
    assign o_rd    = w_hit ? r_value : '0;

endmodule
`default_nettype wire

// ----- src/ilid_or_tree.sv -----
// Two-level registered OR reduction that gathers the one selected cell value.
// Depends on ilid_pkg.
`default_nettype none
module ilid_or_tree (
    input  wire logic                               i_clk,
    input  wire logic [ilid_pkg::VALUE_BITS-1:0]    i_vals [ilid_pkg::CAPACITY],
    output logic      [ilid_pkg::VALUE_BITS-1:0]    o_sum
);

    localparam int PAD = ilid_pkg::NGROUP * ilid_pkg::GROUP;

    logic [ilid_pkg::VALUE_BITS-1:0] w_pad  [PAD];
    logic [ilid_pkg::VALUE_BITS-1:0] n_part [ilid_pkg::NGROUP];
    logic [ilid_pkg::VALUE_BITS-1:0] r_part [ilid_pkg::NGROUP];
    logic [ilid_pkg::VALUE_BITS-1:0] n_sum;
    logic [ilid_pkg::VALUE_BITS-1:0] r_sum;

    for (genvar k = 0; k < PAD; k++) begin : g_pad
        if (k < ilid_pkg::CAPACITY) begin : g_real
            assign w_pad[k] = i_vals[k];
        end else begin : g_zero
            assign w_pad[k] = '0;
        end
    end

    always_comb begin
        for (int g = 0; g < ilid_pkg::NGROUP; g++) begin
            n_part[g] = '0;
            for (int j = 0; j < ilid_pkg::GROUP; j++) begin
                n_part[g] = n_part[g] | w_pad[g * ilid_pkg::GROUP + j];
            end
        end
    end

    always_comb begin
        n_sum = '0;
        for (int g = 0; g < ilid_pkg::NGROUP; g++) begin
            n_sum = n_sum | r_part[g];
        end
    end

    always_ff @(posedge i_clk) begin
        r_part <= n_part;
        r_sum  <= n_sum;
    end

    assign o_sum = r_sum;

endmodule
`default_nettype wire

// ----- src/indexed_list_insert_delete_unit.sv -----
// Top level of the indexed list unit: control sequencer, cell chain and read-out tree.
// Depends on ilid_pkg, ilid_cell and ilid_or_tree.
//
// Use: keeps an ordered list of up to 1024 values of 16 bits. Each transfer on the
// slave stream carries one operation (read at index, insert at head, insert at tail,
// insert before index, delete at index); each one gives exactly one result transfer
// on the master stream with the read value (-1 when there is none), a status
// (done, bad index, full) and the entry count after the operation.
// Entries live in a chain of cells; an insert or delete moves every entry behind the
// touched position by one place, all together in the execute state. A read gathers the selected cell
// through a two-level registered OR tree.
// Sequence: the result passes the execute, tree and hand-off states before it becomes
// valid in the output register. One operation is in flight at a time and tready is high
// only in idle, so a new item is taken only after the last one is handed off.
// Reset: the count and all control state clear, the list is empty; cell contents are
// not cleared and are never seen before they are written.
// Stall: the result sits in an output register; a new item is taken while it waits,
// and the next result holds in the sequencer until the receiver takes the first.
`default_nettype none
module indexed_list_insert_delete_unit (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    // slave stream
    input  wire logic                                i_s_axis_tvalid,
    output logic                                     o_s_axis_tready,
    // tdata from bit 0: op[2:0], index[13:3], value[29:14], zero fill
    input  wire logic [ilid_pkg::IN_DATA_W-1:0]      i_s_axis_tdata,
    // master stream
    output logic                                     o_m_axis_tvalid,
    input  wire logic                                i_m_axis_tready,
    // tdata from bit 0: read_value[16:0], status[18:17], count_now[29:19], zero fill
    output logic      [ilid_pkg::OUT_DATA_W-1:0]     o_m_axis_tdata
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,   // ready for a transfer
        S_EXEC = 4'b0010,   // decide, move the chain, first tree level
        S_TREE = 4'b0100,   // second tree level
        S_DONE = 4'b1000    // hand the result to the output register
    } t_state;

    localparam int OP_LO  = 0;
    localparam int IDX_LO = OP_LO + ilid_pkg::OP_W;
    localparam int VAL_LO = IDX_LO + ilid_pkg::INDEX_W;

    t_state r_state;
    t_state n_state;

    // captured operation
    logic [ilid_pkg::OP_W-1:0]       r_op;
    logic [ilid_pkg::INDEX_W-1:0]    r_pos;
    logic [ilid_pkg::VALUE_BITS-1:0] r_value;

    // list count and per-item result
    logic [ilid_pkg::CNT_W-1:0]      r_count;
    logic [ilid_pkg::CNT_W-1:0]      n_count;
    logic [ilid_pkg::STATUS_W-1:0]   r_status;
    logic [ilid_pkg::STATUS_W-1:0]   n_status;
    logic                            r_rd_ok;
    logic                            n_rd_ok;

    // output register
    logic                            r_out_valid;
    logic [ilid_pkg::OUT_DATA_W-1:0] r_out_data;

    logic                            w_in_xfer;
    logic                            w_out_load;
    logic [ilid_pkg::CMP_W-1:0]      w_cnt_x;
    logic [ilid_pkg::CMP_W-1:0]      w_pos_x;
    logic [ilid_pkg::CMP_W-1:0]      w_ptr;
    ilid_pkg::t_cell_kind            w_kind;
    ilid_pkg::t_cell_cmd             w_cmd;
    logic [ilid_pkg::VALUE_BITS-1:0] w_sum;
    logic [ilid_pkg::READ_W-1:0]     w_read_value;

    logic [ilid_pkg::VALUE_BITS-1:0] w_cell_val [ilid_pkg::CAPACITY];
    logic [ilid_pkg::VALUE_BITS-1:0] w_cell_rd  [ilid_pkg::CAPACITY];

    assign w_in_xfer  = i_s_axis_tvalid && o_s_axis_tready;
    assign w_out_load = (r_state == S_DONE) && (!r_out_valid || i_m_axis_tready);

    assign w_cnt_x = ilid_pkg::CMP_W'(r_count);
    assign w_pos_x = ilid_pkg::CMP_W'(r_pos);

    // Decide the operation against the current count.
    always_comb begin
        w_kind   = ilid_pkg::CELL_HOLD;
        w_ptr    = w_pos_x;
        n_count  = r_count;
        n_status = ilid_pkg::ST_DONE;
        n_rd_ok  = 1'b0;
        case (r_op)
            ilid_pkg::OP_READ: begin
                if (w_pos_x < w_cnt_x) begin
                    n_rd_ok = 1'b1;
                end else begin
                    n_status = ilid_pkg::ST_BAD_INDEX;
                end
            end
            ilid_pkg::OP_INS_HEAD, ilid_pkg::OP_INS_TAIL, ilid_pkg::OP_INS_AT: begin
                if (r_op == ilid_pkg::OP_INS_HEAD) begin
                    w_ptr = '0;
                end else if (r_op == ilid_pkg::OP_INS_TAIL) begin
                    w_ptr = w_cnt_x;
                end
                // index check first, then capacity
                if (w_ptr > w_cnt_x) begin
                    n_status = ilid_pkg::ST_BAD_INDEX;
                end else if (w_cnt_x == ilid_pkg::CMP_W'(ilid_pkg::CAPACITY)) begin
                    n_status = ilid_pkg::ST_FULL;
                end else begin
                    w_kind  = ilid_pkg::CELL_INS;
                    n_count = r_count + 1'b1;
                end
            end
            ilid_pkg::OP_DEL_AT: begin
                if (w_pos_x >= w_cnt_x) begin
                    n_status = ilid_pkg::ST_BAD_INDEX;
                end else begin
                    w_kind  = ilid_pkg::CELL_DEL;
                    n_count = r_count - 1'b1;
                end
            end
            default: begin
                n_status = ilid_pkg::ST_BAD_INDEX;
            end
        endcase
    end

    // Broadcast the command; the chain moves only in the execute cycle.
    assign w_cmd.kind  = (r_state == S_EXEC) ? w_kind : ilid_pkg::CELL_HOLD;
    assign w_cmd.pos   = w_ptr;
    assign w_cmd.value = r_value;

    for (genvar k = 0; k < ilid_pkg::CAPACITY; k++) begin : g_cell
        logic [ilid_pkg::VALUE_BITS-1:0] w_left;
        logic [ilid_pkg::VALUE_BITS-1:0] w_right;

        if (k == 0) begin : g_first
            assign w_left = '0;
        end else begin : g_mid_l
            assign w_left = w_cell_val[k-1];
        end
        if (k == ilid_pkg::CAPACITY - 1) begin : g_last
            assign w_right = '0;
        end else begin : g_mid_r
            assign w_right = w_cell_val[k+1];
        end

        ilid_cell u_cell (
            .i_clk   (i_clk),
            .i_idx   (ilid_pkg::CMP_W'(k)),
            .i_cmd   (w_cmd),
            .i_left  (w_left),
            .i_right (w_right),
            .o_value (w_cell_val[k]),
            .o_rd    (w_cell_rd[k])
        );
    end

    // The tree samples pre-update values in the execute cycle; sum is ready in S_DONE.
    ilid_or_tree u_tree (
        .i_clk  (i_clk),
        .i_vals (w_cell_rd),
        .o_sum  (w_sum)
    );

    assign w_read_value = r_rd_ok ? ilid_pkg::READ_W'(w_sum) : '1;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_xfer) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_TREE;
            end
            S_TREE: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                // hold until the output register is free
                if (w_out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_EXEC) begin
                r_count <= n_count;
            end
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_op    <= i_s_axis_tdata[OP_LO +: ilid_pkg::OP_W];
            r_pos   <= i_s_axis_tdata[IDX_LO +: ilid_pkg::INDEX_W];
            r_value <= ilid_pkg::VALUE_BITS'(i_s_axis_tdata[VAL_LO +: ilid_pkg::INVAL_W]);
        end
        if (r_state == S_EXEC) begin
            r_status <= n_status;
            r_rd_ok  <= n_rd_ok;
        end
        if (w_out_load) begin
            r_out_data <= ilid_pkg::OUT_DATA_W'({ilid_pkg::COUNT_W'(r_count),
                                                 r_status, w_read_value});
        end
    end

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

endmodule
`default_nettype wire

// ----- src/ilid_checker.sv -----
// Port-level checker of the indexed list unit, bound to the top level.
// Depends on ilid_pkg and indexed_list_insert_delete_unit_macros.svh.
`default_nettype none
`include "indexed_list_insert_delete_unit_macros.svh"
module ilid_checker (
    input wire logic                              i_clk,
    input wire logic                              i_rst_n,
    input wire logic                              i_s_axis_tvalid,
    input wire logic                              o_s_axis_tready,
    input wire logic [ilid_pkg::IN_DATA_W-1:0]    i_s_axis_tdata,
    input wire logic                              o_m_axis_tvalid,
    input wire logic                              i_m_axis_tready,
    input wire logic [ilid_pkg::OUT_DATA_W-1:0]   o_m_axis_tdata
);

    localparam int ST_LO  = ilid_pkg::READ_W;
    localparam int CNT_LO = ST_LO + ilid_pkg::STATUS_W;

    logic [ilid_pkg::READ_W-1:0]   w_rd;
    logic [ilid_pkg::STATUS_W-1:0] w_st;
    logic [ilid_pkg::COUNT_W-1:0]  w_cnt;
    logic                          w_in_unused;

    assign w_rd  = o_m_axis_tdata[0 +: ilid_pkg::READ_W];
    assign w_st  = o_m_axis_tdata[ST_LO +: ilid_pkg::STATUS_W];
    assign w_cnt = o_m_axis_tdata[CNT_LO +: ilid_pkg::COUNT_W];
    assign w_in_unused = ^{i_s_axis_tvalid, o_s_axis_tready, i_s_axis_tdata};

    // a stalled result stays put
    `ILID_ASSERT_NEXT(a_out_hold, o_m_axis_tvalid && !i_m_axis_tready,
        o_m_axis_tvalid && $stable(o_m_axis_tdata), "result dropped or changed while stalled")
    // a real read value comes only with a done status
    `ILID_ASSERT_IMP(a_read_done, o_m_axis_tvalid && (w_rd != '1),
        w_st == ilid_pkg::ST_DONE, "read value without done status")
    // a refused insert only happens on a full list
    `ILID_ASSERT_IMP(a_full_count, o_m_axis_tvalid && (w_st == ilid_pkg::ST_FULL),
        w_cnt == ilid_pkg::COUNT_W'(ilid_pkg::CAPACITY), "full status with list not full")
    // count never exceeds capacity and status stays in range
    `ILID_ASSERT_IMP(a_count_range, o_m_axis_tvalid,
        (w_cnt <= ilid_pkg::COUNT_W'(ilid_pkg::CAPACITY)) && (w_st != 2'd3) && !(w_in_unused && 1'b0),
        "count or status out of range")

endmodule

bind indexed_list_insert_delete_unit ilid_checker u_ilid_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .i_s_axis_tdata  (i_s_axis_tdata),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);
`default_nettype wire
